>>> sv/lrukv_pkg.sv
// ----------------------------------------------------------------------------
// lrukv_pkg: shared definitions for the LRU key-value cache
// Field widths, defaults for the top-level parameters, opcode and FSM codes.
// ----------------------------------------------------------------------------
package lrukv_pkg;

  // fixed field widths
  localparam int KEY_BITS   = 32;
  localparam int FIELD_BITS = 32;
  localparam int CAP_BITS   = 5;

  // capacity register after reset
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  // defaults for the top-level parameters
  localparam int ENTRIES_DEFAULT   = 16;
  localparam int DATA_BITS_DEFAULT = 32;

  // request kinds
  typedef enum logic {
    OP_GET = 1'b0,
    OP_SET = 1'b1
  } op_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

>>> sv/lru_key_value_cache.sv
// A response is loaded into the output register as the finish state ends, after
// the scan has read every entry; a full output register not yet taken stalls
// the finish state. A new request is accepted only while idle, once the last
// response is loaded. The scan walks the memory's single read port one entry per cycle.
// Reset clears the valid bits and occupancy and sets capacity_in_use to 16;
// the memory needs no clearing pass and the block is ready right after reset.
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// Keys and values sit in one synchronous memory; valid bits, age ranks and
// occupancy are kept in flops beside it.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int ENTRIES   = lrukv_pkg::ENTRIES_DEFAULT,
  parameter int DATA_BITS = lrukv_pkg::DATA_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration: capacity_in_use
  input  logic                          cfg_wr_en,
  input  logic [lrukv_pkg::CAP_BITS-1:0] cfg_wr_data,
  // request stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [63:0]                   s_axis_tdata,  // key[31:0], write_value[63:32]
  input  logic                          s_axis_tuser,  // opcode[0]
  // response stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [71:0]                   m_axis_tdata   // hit[0], read_value[32:1],
                                                       // evicted[33], evicted_key[65:34],
                                                       // zero[71:66]
);

  localparam int KB = lrukv_pkg::KEY_BITS;
  localparam int FB = lrukv_pkg::FIELD_BITS;
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;    // entry index / rank
  localparam int OW = $clog2(ENTRIES + 1);                    // occupancy / scan count
  localparam int CMPW = (OW > lrukv_pkg::CAP_BITS) ? OW : lrukv_pkg::CAP_BITS;
  localparam int MW = KB + DATA_BITS;

  // control state
  lrukv_pkg::state_t state, state_next;
  logic [lrukv_pkg::CAP_BITS-1:0] capacity;
  logic [ENTRIES-1:0]             valid;
  logic [ENTRIES-1:0]             valid_next;
  logic [OW-1:0]                  occupancy;
  logic [AW-1:0]                  rank [ENTRIES];

  // latched request
  lrukv_pkg::op_t   op;
  logic [KB-1:0]    key;
  logic [DATA_BITS-1:0] wr_val;

  // scan bookkeeping
  logic [OW-1:0]        cnt;
  logic                 rd_pend;
  logic [AW-1:0]        rd_idx;
  logic                 found;
  logic [AW-1:0]        hit_slot;
  logic [AW-1:0]        hit_rank;
  logic [DATA_BITS-1:0] hit_val;
  logic                 free_found;
  logic [AW-1:0]        free_slot;
  logic                 old_found;
  logic [AW-1:0]        old_slot;
  logic [KB-1:0]        old_key;

  // memory ports
  logic [MW-1:0] mem [ENTRIES];
  logic [MW-1:0] mem_q;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;

  // output register
  logic        out_valid;
  logic [71:0] out_data;
  logic [71:0] resp_word;

  // finish-cycle decisions
  logic          s_fire;
  logic          fin_fire;
  logic          evict_now;
  logic [AW-1:0] ins_slot;
  logic [ENTRIES-1:0] is_oldest;
  logic [KB-1:0] mem_key;
  logic [DATA_BITS-1:0] mem_val;

  assign s_axis_tready = (state == lrukv_pkg::ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign fin_fire      = (state == lrukv_pkg::ST_FINISH) && (!out_valid || m_axis_tready);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  assign mem_key = mem_q[KB-1:0];
  assign mem_val = mem_q[MW-1:KB];

  // least recent valid entry: its rank is occupancy - 1
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      is_oldest[i] = valid[i] && (OW'(rank[i]) == occupancy - OW'(1));
    end
  end

  // eviction on a set miss once the effective capacity is reached
  // (capacity 0 behaves as 1, capacity above ENTRIES as ENTRIES)
  assign evict_now = (occupancy != '0) &&
                     ((CMPW'(occupancy) >= CMPW'(capacity)) || (occupancy == OW'(ENTRIES)));

  // insert into the lowest free slot, the evicted one included
  assign ins_slot = (evict_now && (!free_found || old_slot < free_slot)) ? old_slot : free_slot;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrukv_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_re     = 1'b0;
    mem_raddr  = cnt[AW-1:0];
    mem_we     = 1'b0;
    mem_waddr  = ins_slot;
    mem_wdata  = {wr_val, key};
    case (state)
      lrukv_pkg::ST_IDLE: begin
        if (s_fire) state_next = lrukv_pkg::ST_SCAN;
      end
      lrukv_pkg::ST_SCAN: begin
        mem_re = (cnt != OW'(ENTRIES));
        if (cnt == OW'(ENTRIES)) state_next = lrukv_pkg::ST_FINISH;
      end
      lrukv_pkg::ST_FINISH: begin
        if (fin_fire) begin
          state_next = lrukv_pkg::ST_IDLE;
          if (op == lrukv_pkg::OP_SET) begin
            mem_we    = 1'b1;
            mem_waddr = found ? hit_slot : ins_slot;
          end
        end
      end
      default: state_next = lrukv_pkg::ST_IDLE;
    endcase
  end

  // key/value memory; scan reads and finish writes never share a cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_q <= mem[mem_raddr];
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lrukv_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  // request latch and scan
  always_ff @(posedge clk) begin
    if (s_fire) begin
      op         <= lrukv_pkg::op_t'(s_axis_tuser);
      key        <= s_axis_tdata[31:0];
      wr_val     <= DATA_BITS'(s_axis_tdata[63:32]);
      cnt        <= '0;
      rd_pend    <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
      old_found  <= 1'b0;
    end else if (state == lrukv_pkg::ST_SCAN) begin
      // issue stage
      if (cnt != OW'(ENTRIES)) begin
        cnt     <= cnt + OW'(1);
        rd_pend <= 1'b1;
        rd_idx  <= cnt[AW-1:0];
      end else begin
        rd_pend <= 1'b0;
      end
      // compare stage on last cycle's read
      if (rd_pend) begin
        if (valid[rd_idx] && mem_key == key && !found) begin
          found    <= 1'b1;
          hit_slot <= rd_idx;
          hit_rank <= rank[rd_idx];
          hit_val  <= mem_val;
        end
        if (is_oldest[rd_idx]) begin
          old_found <= 1'b1;
          old_slot  <= rd_idx;
          old_key   <= mem_key;
        end
        if (!valid[rd_idx] && !free_found) begin
          free_found <= 1'b1;
          free_slot  <= rd_idx;
        end
      end
    end
  end

  // valid bits after a set miss: victim dropped, new entry marked
  always_comb begin
    valid_next = valid;
    if (evict_now) valid_next[old_slot] = 1'b0;
    valid_next[ins_slot] = 1'b1;
  end

  // valid bits and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      occupancy <= '0;
    end else if (fin_fire && op == lrukv_pkg::OP_SET && !found) begin
      valid <= valid_next;
      if (!evict_now) occupancy <= occupancy + OW'(1);
    end
  end

  // age ranks, one update cell per entry
  always_ff @(posedge clk) begin
    if (fin_fire && op == lrukv_pkg::OP_SET) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (found) begin
          if (AW'(i) == hit_slot) rank[i] <= '0;
          else if (valid[i] && rank[i] < hit_rank) rank[i] <= rank[i] + AW'(1);
        end else begin
          if (AW'(i) == ins_slot) rank[i] <= '0;
          else if (valid[i] && !(evict_now && AW'(i) == old_slot)) rank[i] <= rank[i] + AW'(1);
        end
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // response word built from the scan results
  always_comb begin
    resp_word    = '0;
    resp_word[0] = found;
    if (op == lrukv_pkg::OP_GET) begin
      resp_word[32:1] = found ? FB'(hit_val) : '1;
    end else if (!found && evict_now) begin
      resp_word[33]    = 1'b1;
      resp_word[65:34] = old_key;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      out_data <= resp_word;
    end
  end

  // ---------------- assertions ----------------
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= OW'(ENTRIES))
    else $error("occupancy above entry count");

  a_occ_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(occupancy))
    else $error("occupancy out of step with valid bits");

  a_evict_has_victim: assert property (@(posedge clk) disable iff (rst)
    (fin_fire && op == lrukv_pkg::OP_SET && !found && evict_now) |-> old_found)
    else $error("eviction without a least recent entry");

  a_insert_has_slot: assert property (@(posedge clk) disable iff (rst)
    (fin_fire && op == lrukv_pkg::OP_SET && !found) |-> (free_found || evict_now))
    else $error("insert without a free slot");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("memory read and write in the same cycle");

endmodule
